// ----- design/tts_pkg.sv -----
`default_nettype none

package tts_pkg;

    localparam int LEVEL_W      = 16;
    localparam int HOUR_W       = 5;
    localparam int MINUTE_W     = 6;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 2;

    localparam logic [HOUR_W-1:0]   HOURS_PER_DAY    = 5'd24;
    localparam logic [MINUTE_W-1:0] MINUTES_PER_HOUR = 6'd60;
    localparam logic [LEVEL_W-1:0]  THRESHOLD_RESET  = 16'd40;

    // Register byte addresses
    localparam logic [APB_ADDR_W-1:0] ADDR_TOUCH_THRESHOLD = 2'd0;

    typedef struct packed {
        logic [LEVEL_W-1:0]  enable_level;
        logic [LEVEL_W-1:0]  increment_level;
        logic [LEVEL_W-1:0]  decrement_level;
        logic [LEVEL_W-1:0]  select_level;
        logic [HOUR_W-1:0]   clock_hour;
        logic [MINUTE_W-1:0] clock_minute;
    } poll_t;

    typedef struct packed {
        logic                setting_active;
        logic                minute_selected;
        logic [HOUR_W-1:0]   shown_hour;
        logic [MINUTE_W-1:0] shown_minute;
        logic                commit;
    } result_t;

    // Step up with wrap to zero at the modulus
    function automatic logic [MINUTE_W-1:0] wrap_up(
        input logic [MINUTE_W-1:0] v,
        input logic [MINUTE_W-1:0] modulus
    );
        logic [MINUTE_W:0] inc;
        inc = {1'b0, v} + {{MINUTE_W{1'b0}}, 1'b1};
        wrap_up = (inc >= {1'b0, modulus}) ? '0 : inc[MINUTE_W-1:0];
    endfunction

    // Step down with wrap to modulus-1 at zero or when out of range
    function automatic logic [MINUTE_W-1:0] wrap_down(
        input logic [MINUTE_W-1:0] v,
        input logic [MINUTE_W-1:0] modulus
    );
        wrap_down = (v == '0 || v >= modulus) ? modulus - 6'd1 : v - 6'd1;
    endfunction

endpackage

`default_nettype wire

// ----- design/tts_cfg_regs.sv -----
`default_nettype none

module tts_cfg_regs
    import tts_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [LEVEL_W-1:0]    touch_threshold
);

    logic [LEVEL_W-1:0] threshold_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == ADDR_TOUCH_THRESHOLD);

    // Write the threshold on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (wr_en)
        begin
            threshold_reg <= pwdata[LEVEL_W-1:0];
        end
    end

    // Read back; unmapped addresses return zero
    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_TOUCH_THRESHOLD)
        begin
            prdata = {{(APB_DATA_W-LEVEL_W){1'b0}}, threshold_reg};
        end
    end

    assign touch_threshold = threshold_reg;

endmodule

`default_nettype wire

// ----- design/tts_step.sv -----
`default_nettype none

module tts_step
    import tts_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire poll_t              poll_in,
    input  wire logic [LEVEL_W-1:0] touch_threshold,
    output result_t                 result_next
);

    logic [3:0]          touched_reg;   // enable, increment, decrement, select
    logic [3:0]          touched_next;
    logic                mode_reg, mode_next;
    logic                minsel_reg, minsel_next;
    logic [HOUR_W-1:0]   hour_reg, hour_next;
    logic [MINUTE_W-1:0] minute_reg, minute_next;
    logic                commit_next;
    logic                en_press, inc_press, dec_press, sel_press;
    logic [HOUR_W-1:0]   hour_load;
    logic [MINUTE_W-1:0] minute_load;
    logic [MINUTE_W-1:0] hour_up, hour_dn;

    // Sample the pads against the threshold
    assign touched_next = {poll_in.enable_level    < touch_threshold,
                           poll_in.increment_level < touch_threshold,
                           poll_in.decrement_level < touch_threshold,
                           poll_in.select_level    < touch_threshold};

    // Detect presses as rising edges of the touched flags
    assign en_press  = touched_next[3] && !touched_reg[3];
    assign inc_press = touched_next[2] && !touched_reg[2];
    assign dec_press = touched_next[1] && !touched_reg[1];
    assign sel_press = touched_next[0] && !touched_reg[0];

    // Clamp the clock time on load
    assign hour_load   = (poll_in.clock_hour > HOURS_PER_DAY - 5'd1) ?
                         HOURS_PER_DAY - 5'd1 : poll_in.clock_hour;
    assign minute_load = (poll_in.clock_minute > MINUTES_PER_HOUR - 6'd1) ?
                         MINUTES_PER_HOUR - 6'd1 : poll_in.clock_minute;

    assign hour_up = wrap_up({1'b0, hour_reg}, {1'b0, HOURS_PER_DAY});
    assign hour_dn = wrap_down({1'b0, hour_reg}, {1'b0, HOURS_PER_DAY});

    // Apply the highest priority press
    always_comb
    begin
        mode_next   = mode_reg;
        minsel_next = minsel_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        commit_next = 1'b0;
        if (!mode_reg)
        begin
            if (en_press)
            begin
                mode_next   = 1'b1;
                minsel_next = 1'b0;
                hour_next   = hour_load;
                minute_next = minute_load;
            end
        end
        else if (en_press)
        begin
            mode_next   = 1'b0;
            commit_next = 1'b1;
        end
        else if (sel_press)
        begin
            minsel_next = !minsel_reg;
        end
        else if (inc_press)
        begin
            if (minsel_reg)
            begin
                minute_next = wrap_up(minute_reg, MINUTES_PER_HOUR);
            end
            else
            begin
                hour_next = hour_up[HOUR_W-1:0];
            end
        end
        else if (dec_press)
        begin
            if (minsel_reg)
            begin
                minute_next = wrap_down(minute_reg, MINUTES_PER_HOUR);
            end
            else
            begin
                hour_next = hour_dn[HOUR_W-1:0];
            end
        end
    end

    // Advance the edit state once per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touched_reg <= '0;
            mode_reg    <= 1'b0;
            minsel_reg  <= 1'b0;
            hour_reg    <= '0;
            minute_reg  <= '0;
        end
        else if (advance)
        begin
            touched_reg <= touched_next;
            mode_reg    <= mode_next;
            minsel_reg  <= minsel_next;
            hour_reg    <= hour_next;
            minute_reg  <= minute_next;
        end
    end

    assign result_next = '{setting_active:  mode_next,
                           minute_selected: minsel_next,
                           shown_hour:      hour_next,
                           shown_minute:    minute_next,
                           commit:          commit_next};

endmodule

`default_nettype wire

// ----- design/touch_time_set_controller_core.sv -----
`default_nettype none

// Channel   | Handshake                  | Payload
// ----------+----------------------------+------------------------------
// poll      | poll_valid / poll_stall    | poll_t: four pad levels, clock
// result    | result_valid / result_stall| result_t: mode, edit time, commit
// config    | APB psel/penable/pready    | touch_threshold at byte address 0
//
// One transaction per cycle unless the result stalls: a poll is captured in
// the input register, the edge and mode update runs on it, and the result
// register follows, so a result is valid after both registers. The input
// register takes a new poll while the result register drains. Reset clears
// the edit state and sets the threshold to 40. A stalled result holds and
// backs up a stall onto the poll channel only when both registers are full.

module touch_time_set_controller_core
    import tts_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  poll_valid,
    output logic                       poll_stall,
    input  wire poll_t                 poll,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output result_t                    result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic               in_valid_reg;
    poll_t              in_reg;
    logic               out_valid_reg;
    result_t            out_reg;
    result_t            result_next;
    logic               out_free;
    logic               advance;
    logic               accept;
    logic [LEVEL_W-1:0] touch_threshold;

    tts_cfg_regs u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .touch_threshold (touch_threshold)
    );

    tts_step u_step (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .poll_in         (in_reg),
        .touch_threshold (touch_threshold),
        .result_next     (result_next)
    );

    assign out_free   = !out_valid_reg || !result_stall;
    assign advance    = in_valid_reg && out_free;
    assign poll_stall = in_valid_reg && !out_free;
    assign accept     = poll_valid && !poll_stall;

    // Capture a poll when the input register is empty or draining
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!poll_stall)
        begin
            in_valid_reg <= poll_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= poll;
        end
    end

    // Load the result register, hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef SYNTH
    // A commit always leaves setting mode
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.commit) |-> !result.setting_active)
        else $error("commit reported while still in setting mode");

    // Edited time stays in range
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.shown_hour < HOURS_PER_DAY &&
                          result.shown_minute < MINUTES_PER_HOUR))
        else $error("edited time out of range");

    // Backpressure only when both registers are occupied and the sink stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        poll_stall |-> (out_valid_reg && result_stall))
        else $error("poll stalled with room in the pipeline");
`endif

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
module tb;
    import tts_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 6;
    localparam int TIMEOUT_CYCLES = 200000;

    // Tracks pad edges and the edited time; holds the results still due
    class time_set_scoreboard;
        logic [LEVEL_W-1:0]  threshold;
        bit                  enable_held;
        bit                  increment_held;
        bit                  decrement_held;
        bit                  select_held;
        bit                  setting;
        bit                  minute_sel;
        logic [HOUR_W-1:0]   edit_hour;
        logic [MINUTE_W-1:0] edit_minute;
        result_t             due_results[$];
        int                  errors;

        function new();
            threshold      = THRESHOLD_RESET;
            enable_held    = 1'b0;
            increment_held = 1'b0;
            decrement_held = 1'b0;
            select_held    = 1'b0;
            setting        = 1'b0;
            minute_sel     = 1'b0;
            edit_hour      = '0;
            edit_minute    = '0;
            errors         = 0;
        endfunction

        function void report(string what);
            errors++;
            if (errors <= 10)
                $display("mismatch: %s", what);
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // Work out the result of one accepted poll
        function void take_poll(poll_t p);
            bit      en_now, inc_now, dec_now, sel_now;
            bit      en_press, inc_press, dec_press, sel_press;
            bit      committing;
            result_t r;
            en_now    = p.enable_level < threshold;
            inc_now   = p.increment_level < threshold;
            dec_now   = p.decrement_level < threshold;
            sel_now   = p.select_level < threshold;
            en_press  = en_now && !enable_held;
            inc_press = inc_now && !increment_held;
            dec_press = dec_now && !decrement_held;
            sel_press = sel_now && !select_held;
            enable_held    = en_now;
            increment_held = inc_now;
            decrement_held = dec_now;
            select_held    = sel_now;
            committing = 1'b0;

            if (!setting) begin
                // enter: load the clock, clamped into range, hour selected
                if (en_press) begin
                    setting    = 1'b1;
                    minute_sel = 1'b0;
                    edit_hour  = (p.clock_hour > HOURS_PER_DAY - 1) ?
                                 HOURS_PER_DAY - 1 : p.clock_hour;
                    edit_minute = (p.clock_minute > MINUTES_PER_HOUR - 1) ?
                                  MINUTES_PER_HOUR - 1 : p.clock_minute;
                end
            end else if (en_press) begin
                setting    = 1'b0;
                committing = 1'b1;
            end else if (sel_press) begin
                minute_sel = !minute_sel;
            end else if (inc_press) begin
                if (minute_sel)
                    edit_minute = (edit_minute + 1 >= MINUTES_PER_HOUR) ? '0 : edit_minute + 1;
                else
                    edit_hour = (edit_hour + 1 >= HOURS_PER_DAY) ? '0 : edit_hour + 1;
            end else if (dec_press) begin
                if (minute_sel)
                    edit_minute = (edit_minute == 0 || edit_minute >= MINUTES_PER_HOUR) ?
                                  MINUTES_PER_HOUR - 1 : edit_minute - 1;
                else
                    edit_hour = (edit_hour == 0 || edit_hour >= HOURS_PER_DAY) ?
                                HOURS_PER_DAY - 1 : edit_hour - 1;
            end

            r.setting_active  = setting;
            r.minute_selected = minute_sel;
            r.shown_hour      = edit_hour;
            r.shown_minute    = edit_minute;
            r.commit          = committing;
            due_results.push_back(r);
        endfunction

        function void compare(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
                report($sformatf("%s expected %0d got %0d", name, want, got));
        endfunction

        // Compare one accepted result with the oldest one due
        function void check_result(result_t got);
            result_t want;
            if (due_results.size() == 0) begin
                report($sformatf("result %h arrived with none due", got));
                return;
            end
            want = due_results.pop_front();
            compare("setting_active", want.setting_active, got.setting_active);
            compare("minute_selected", want.minute_selected, got.minute_selected);
            compare("shown_hour", want.shown_hour, got.shown_hour);
            compare("shown_minute", want.shown_minute, got.shown_minute);
            compare("commit", want.commit, got.commit);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  poll_valid = 1'b0;
    logic                  poll_stall;
    poll_t                 poll_data = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    time_set_scoreboard    sb;
    int                    sender_idle_pct = 0;
    int                    receiver_idle_pct = 0;
    int                    cur_threshold = THRESHOLD_RESET;

    touch_time_set_controller_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .poll_valid   (poll_valid),
        .poll_stall   (poll_stall),
        .poll         (poll_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Take results and stall at random
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result_data);
        result_stall <= ($urandom_range(99, 0) < receiver_idle_pct);
    end

    // Pick a pad reading on the requested side of the threshold, edges included
    function automatic logic [LEVEL_W-1:0] pad_level(bit touched);
        int thr;
        thr = cur_threshold;
        if (touched && thr > 0) begin
            case ($urandom_range(3, 0))
                0:       return '0;
                1:       return thr - 1;
                default: return $urandom_range(thr - 1, 0);
            endcase
        end
        if (touched)
            return $urandom;
        case ($urandom_range(3, 0))
            0:       return 16'hFFFF;
            1:       return thr;
            default: return $urandom_range(65535, thr);
        endcase
    endfunction

    function automatic poll_t make_poll(bit en, bit sel, bit inc, bit dec,
                                        logic [HOUR_W-1:0] hour,
                                        logic [MINUTE_W-1:0] minute);
        poll_t p;
        p.enable_level    = pad_level(en);
        p.select_level    = pad_level(sel);
        p.increment_level = pad_level(inc);
        p.decrement_level = pad_level(dec);
        p.clock_hour      = hour;
        p.clock_minute    = minute;
        return p;
    endfunction

    // Mostly pad sequences around the threshold, some raw noise
    function automatic poll_t random_poll(int enable_pct);
        poll_t               p;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        hour   = ($urandom_range(4, 0) == 0) ? $urandom_range(31, 0) : $urandom_range(23, 0);
        minute = ($urandom_range(4, 0) == 0) ? $urandom_range(63, 0) : $urandom_range(59, 0);
        if ($urandom_range(9, 0) == 0) begin
            p.enable_level    = $urandom;
            p.select_level    = $urandom;
            p.increment_level = $urandom;
            p.decrement_level = $urandom;
            p.clock_hour      = hour;
            p.clock_minute    = minute;
            return p;
        end
        return make_poll($urandom_range(99, 0) < enable_pct, $urandom_range(99, 0) < 40,
                         $urandom_range(99, 0) < 40, $urandom_range(99, 0) < 40, hour, minute);
    endfunction

    // Offer one poll, idling first at random, and hold it until taken
    task automatic send_poll(input poll_t p);
        while ($urandom_range(99, 0) < sender_idle_pct)
        begin
            poll_valid <= 1'b0;
            @(posedge clk);
        end
        poll_valid <= 1'b1;
        poll_data  <= p;
        @(posedge clk);
        while (poll_stall)
            @(posedge clk);
        sb.take_poll(p);
    endtask

    // Hold off new polls until every result has come back
    task automatic drain_results();
        poll_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the threshold, junk in the upper bits, then read it back
    task automatic write_threshold(input logic [LEVEL_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TOUCH_THRESHOLD;
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.threshold  = value;
        cur_threshold = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[LEVEL_W-1:0] !== value)
            sb.report($sformatf("threshold read %h after write %h", prdata, value));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_random(input int count, input int enable_pct);
        for (int i = 0; i < count; i++)
        begin
            send_poll(random_poll(enable_pct));
            if ($urandom_range(149, 0) == 0)
                drain_results();
        end
    endtask

    // Walk the edit flow: clamp, wraps, priorities, held pads, commit
    task automatic run_directed();
        send_poll(make_poll(0, 0, 0, 0, 5'd31, 6'd63));
        send_poll(make_poll(1, 1, 1, 1, 5'd31, 6'd63));
        send_poll(make_poll(0, 0, 0, 0, 5'd0, 6'd0));
        send_poll(make_poll(0, 0, 1, 0, 5'd7, 6'd7));
        send_poll(make_poll(0, 0, 0, 0, 5'd7, 6'd7));
        send_poll(make_poll(0, 0, 0, 1, 5'd7, 6'd7));
        send_poll(make_poll(0, 0, 0, 0, 5'd7, 6'd7));
        send_poll(make_poll(0, 1, 0, 0, 5'd7, 6'd7));
        send_poll(make_poll(0, 0, 0, 0, 5'd7, 6'd7));
        send_poll(make_poll(0, 0, 1, 0, 5'd7, 6'd7));
        send_poll(make_poll(0, 0, 0, 0, 5'd7, 6'd7));
        send_poll(make_poll(0, 0, 0, 1, 5'd7, 6'd7));
        send_poll(make_poll(0, 0, 0, 0, 5'd7, 6'd7));
        send_poll(make_poll(0, 1, 1, 1, 5'd7, 6'd7));
        send_poll(make_poll(0, 0, 0, 0, 5'd7, 6'd7));
        send_poll(make_poll(0, 0, 1, 1, 5'd7, 6'd7));
        send_poll(make_poll(0, 0, 0, 0, 5'd7, 6'd7));
        send_poll(make_poll(1, 1, 0, 0, 5'd12, 6'd30));
        send_poll(make_poll(1, 0, 0, 0, 5'd12, 6'd30));
        send_poll(make_poll(0, 0, 0, 0, 5'd12, 6'd30));
        send_poll(make_poll(1, 0, 0, 0, 5'd0, 6'd0));
        send_poll(make_poll(0, 0, 0, 0, 5'd0, 6'd0));
        send_poll(make_poll(1, 0, 0, 0, 5'd0, 6'd0));
    endtask

    initial
    begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles less than the receiver
        sender_idle_pct   = 38;
        receiver_idle_pct = 54;
        run_directed();
        run_random(450, 15);
        drain_results();
        write_threshold(16'd0);
        run_random(50, 15);
        drain_results();

        // swap idling sides
        sender_idle_pct   = 54;
        receiver_idle_pct = 38;
        write_threshold(16'hFFFF);
        run_random(50, 15);
        drain_results();
        write_threshold($urandom_range(2000, 1));
        run_random(400, 15);
        drain_results();

        // back to back, long edit sessions
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        write_threshold($urandom);
        run_random(250, 6);
        drain_results();
        write_threshold(THRESHOLD_RESET);
        run_random(300, 10);
        drain_results();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- files.f -----
design/tts_pkg.sv
design/tts_cfg_regs.sv
design/tts_step.sv
design/touch_time_set_controller_core.sv
tb/tb.sv
